### hw/rtl/qer_pkg.sv
// Shared types, fixed-point constants and the arctangent table for the quaternion rotator.
package qer_pkg;

   // Quaternion fraction bits and angle field width
   localparam int FRAC_BITS  = 14;
   localparam int ANGLE_BITS = 16;

   // Width of Q30 CORDIC words (x, y, z and the sine/cosine results)
   localparam int CW = 34;

   // CORDIC start value 1/K and pi, both in Q30
   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [CW-1:0] PI_Q30   = 34'sd3373259426;

   typedef struct packed {
      logic signed [15:0] q_w;
      logic signed [15:0] q_x;
      logic signed [15:0] q_y;
      logic signed [15:0] q_z;
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] r_w;
      logic signed [15:0] r_x;
      logic signed [15:0] r_y;
      logic signed [15:0] r_z;
   } rsp_type;

   // atan(2^-idx) in Q30, rounded
   function automatic logic signed [CW-1:0] atan_q30(input int idx);
      logic signed [CW-1:0] v;
      case (idx)
         0: v = 34'sd843314857;
         1: v = 34'sd497837829;
         2: v = 34'sd263043837;
         3: v = 34'sd133525159;
         4: v = 34'sd67021687;
         5: v = 34'sd33543516;
         6: v = 34'sd16775851;
         7: v = 34'sd8388437;
         8: v = 34'sd4194283;
         9: v = 34'sd2097149;
         default: begin
            if (idx < 30) v = 34'sd1 <<< (30 - idx);
            else v = 34'sd1;
         end
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/quaternion_euler_rotate.sv
// Top level: rotates a Q2.14 quaternion by a ZYX Euler rotation, fully pipelined.
//
//   channel   ports                    handshake
//   request   req_data                 start high, busy low at the clock edge
//   response  rsp_data                 rsp_valid high for one cycle
//
// One beat enters per cycle while busy is low; each result passes through one angle
// scaling stage, one CORDIC stage per iteration (CORDIC_STAGES, capped at 32), two for the
// rotation quaternion and four for the conjugation product.
// busy is high only while reset is held; reset clears every valid bit in flight.
// The response side has no stall: every result is shown for exactly one cycle.
module quaternion_euler_rotate #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qer_pkg::req_type req_data,
   output logic             rsp_valid,
   output qer_pkg::rsp_type rsp_data
);

   localparam int NS    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int QDLY  = NS + 3;
   localparam int LAT   = NS + 7;
   localparam int CW    = qer_pkg::CW;

   logic                 req_fire;
   logic signed [15:0]   angle [3];
   logic signed [15:0]   q_ff [QDLY][4];
   logic                 cs_valid, r_valid;
   logic signed [CW-1:0] cs_cos [3];
   logic signed [CW-1:0] cs_sin [3];
   logic signed [CW-1:0] rq [4];

   assign busy     = reset;
   assign req_fire = start && !busy;

   assign angle[0] = req_data.roll_angle;
   assign angle[1] = req_data.pitch_angle;
   assign angle[2] = req_data.yaw_angle;

   // Delay the quaternion to meet the rotation quaternion
   always_ff @(posedge clock) begin
      q_ff[0][0] <= req_data.q_w;
      q_ff[0][1] <= req_data.q_x;
      q_ff[0][2] <= req_data.q_y;
      q_ff[0][3] <= req_data.q_z;
      for (int k = 1; k < QDLY; k++) begin
         q_ff[k] <= q_ff[k-1];
      end
   end

   qer_cordic #(.STAGES(NS)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (req_fire),
      .angle_in  (angle),
      .valid_out (cs_valid),
      .cos_out   (cs_cos),
      .sin_out   (cs_sin)
   );

   qer_rotq u_rotq (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (cs_valid),
      .cos_in    (cs_cos),
      .sin_in    (cs_sin),
      .valid_out (r_valid),
      .r_out     (rq)
   );

   qer_hamilton u_hamilton (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (r_valid),
      .q_in      (q_ff[QDLY-1]),
      .r_in      (rq),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // Every accepted beat yields a result after the pipeline latency
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##LAT rsp_valid)
      else $error("accepted beat produced no result");

   // No result appears without a beat accepted one latency earlier
   a_rsp_has_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_fire, LAT))
      else $error("result without an accepted beat");

   // The rotation stage passes each CORDIC beat on through its valid registers v1_ff and v2_ff
   a_mid_valid: assert property (@(posedge clock) disable iff (reset)
      cs_valid |-> ##2 r_valid)
      else $error("rotation stage valid out of step");
`endif

endmodule

### hw/rtl/qer_cordic.sv
// Three-lane pipelined CORDIC giving cosine and sine of the half roll, pitch and yaw angles.
module qer_cordic #(
   parameter int STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   input  logic signed [15:0]            angle_in [3],
   output logic                          valid_out,
   output logic signed [qer_pkg::CW-1:0] cos_out [3],
   output logic signed [qer_pkg::CW-1:0] sin_out [3]
);

   localparam int CW = qer_pkg::CW;
   localparam int MW = CW + 16;
   localparam logic signed [MW-1:0] HALF_A = MW'(1) <<< (qer_pkg::ANGLE_BITS - 1);

   logic                 valid_ff [STAGES+1];
   logic signed [CW-1:0] x_ff [3][STAGES+1];
   logic signed [CW-1:0] y_ff [3][STAGES+1];
   logic signed [CW-1:0] z_ff [3][STAGES+1];

   // Advance valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= valid_in;
      end
   end

   genvar gl, gs;
   for (gs = 0; gs < STAGES; gs++) begin : g_valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[gs+1] <= 1'b0;
         end else begin
            valid_ff[gs+1] <= valid_ff[gs];
         end
      end
   end

   for (gl = 0; gl < 3; gl++) begin : g_lane
      logic signed [MW-1:0] prod;

      // Scale the binary angle to a Q30 half angle in radians
      assign prod = MW'(angle_in[gl]) * MW'(qer_pkg::PI_Q30);

      always_ff @(posedge clock) begin
         x_ff[gl][0] <= qer_pkg::GAIN_Q30;
         y_ff[gl][0] <= '0;
         z_ff[gl][0] <= CW'((prod + HALF_A) >>> qer_pkg::ANGLE_BITS);
      end

      for (gs = 0; gs < STAGES; gs++) begin : g_stage
         localparam logic signed [CW-1:0] ATAN = qer_pkg::atan_q30(gs);
         logic signed [CW-1:0] x_in, y_in, z_in;

         // Rotate toward zero residual angle
         always_comb begin
            if (!z_ff[gl][gs][CW-1]) begin
               x_in = x_ff[gl][gs] - (y_ff[gl][gs] >>> gs);
               y_in = y_ff[gl][gs] + (x_ff[gl][gs] >>> gs);
               z_in = z_ff[gl][gs] - ATAN;
            end else begin
               x_in = x_ff[gl][gs] + (y_ff[gl][gs] >>> gs);
               y_in = y_ff[gl][gs] - (x_ff[gl][gs] >>> gs);
               z_in = z_ff[gl][gs] + ATAN;
            end
         end

         always_ff @(posedge clock) begin
            x_ff[gl][gs+1] <= x_in;
            y_ff[gl][gs+1] <= y_in;
            z_ff[gl][gs+1] <= z_in;
         end
      end

      assign cos_out[gl] = x_ff[gl][STAGES];
      assign sin_out[gl] = y_ff[gl][STAGES];
   end

   assign valid_out = valid_ff[STAGES];

endmodule

### hw/rtl/qer_rotq.sv
// Two-stage builder of the ZYX rotation quaternion from half-angle sines and cosines.
module qer_rotq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   input  logic signed [qer_pkg::CW-1:0] cos_in [3],
   input  logic signed [qer_pkg::CW-1:0] sin_in [3],
   output logic                          valid_out,
   output logic signed [qer_pkg::CW-1:0] r_out [4]
);

   localparam int CW = qer_pkg::CW;

   // Q30 product rounded back to Q30
   function automatic logic signed [CW-1:0] m30(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] p;
      p = (2*CW)'(a) * (2*CW)'(b);
      p = p + ((2*CW)'(1) <<< 29);
      return CW'(p >>> 30);
   endfunction

   logic                 v1_ff, v2_ff;
   logic signed [CW-1:0] cycr_ff, sysr_ff, cysr_ff, sycr_ff, cp_ff, sp_ff;
   logic signed [CW-1:0] r_ff [4];

   // Hold the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
      end
   end

   // Form yaw by roll products; lane 0 roll, 1 pitch, 2 yaw
   always_ff @(posedge clock) begin
      cycr_ff <= m30(cos_in[2], cos_in[0]);
      sysr_ff <= m30(sin_in[2], sin_in[0]);
      cysr_ff <= m30(cos_in[2], sin_in[0]);
      sycr_ff <= m30(sin_in[2], cos_in[0]);
      cp_ff   <= cos_in[1];
      sp_ff   <= sin_in[1];
   end

   // Fold in pitch
   always_ff @(posedge clock) begin
      r_ff[0] <= m30(cycr_ff, cp_ff) + m30(sysr_ff, sp_ff);
      r_ff[1] <= m30(cysr_ff, cp_ff) - m30(sycr_ff, sp_ff);
      r_ff[2] <= m30(cycr_ff, sp_ff) + m30(sysr_ff, cp_ff);
      r_ff[3] <= m30(sycr_ff, cp_ff) - m30(cysr_ff, sp_ff);
   end

   assign valid_out = v2_ff;
   assign r_out     = r_ff;

endmodule

### hw/rtl/qer_hamilton.sv
// Four-stage conjugation q * r * conj(q) with rounding and saturation to Q2.14.
module qer_hamilton (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   input  logic signed [15:0]            q_in [4],
   input  logic signed [qer_pkg::CW-1:0] r_in [4],
   output logic                          rsp_valid,
   output qer_pkg::rsp_type              rsp_data
);

   localparam int CW  = qer_pkg::CW;
   localparam int P1W = CW + 16;
   localparam int S1W = P1W + 2;
   localparam int PW  = 36;
   localparam int P2W = PW + 16;
   localparam int S2W = P2W + 2;
   localparam logic signed [S1W-1:0] HALF_P = S1W'(1) <<< (qer_pkg::FRAC_BITS - 1);
   localparam logic signed [S2W-1:0] HALF_O = S2W'(1) <<< 29;

   // Round off 30 bits and clamp to 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [S2W-1:0] s);
      logic signed [S2W-1:0] v;
      v = (s + HALF_O) >>> 30;
      if (v > S2W'(32767)) return 16'sh7fff;
      if (v < -S2W'(32768)) return 16'sh8000;
      return v[15:0];
   endfunction

   logic                  v_ff [4];
   logic signed [P1W-1:0] m_ff [4][4];
   logic signed [15:0]    q1_ff [4];
   logic signed [15:0]    q2_ff [4];
   logic signed [PW-1:0]  p_ff [4];
   logic signed [P2W-1:0] n_ff [4][4];
   qer_pkg::rsp_type      rsp_ff;
   logic signed [S1W-1:0] ps [4];
   logic signed [S2W-1:0] os [4];

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '{default: 1'b0};
      end else begin
         v_ff[0] <= valid_in;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
      end
   end

   // Stage one: all q by r partial products
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            m_ff[i][j] <= P1W'(q_in[i]) * P1W'(r_in[j]);
         end
      end
      q1_ff <= q_in;
   end

   // Sum q * r in Q(FRAC+30)
   always_comb begin
      ps[0] = S1W'(m_ff[0][0]) - S1W'(m_ff[1][1]) - S1W'(m_ff[2][2]) - S1W'(m_ff[3][3]);
      ps[1] = S1W'(m_ff[0][1]) + S1W'(m_ff[1][0]) + S1W'(m_ff[2][3]) - S1W'(m_ff[3][2]);
      ps[2] = S1W'(m_ff[0][2]) + S1W'(m_ff[2][0]) + S1W'(m_ff[3][1]) - S1W'(m_ff[1][3]);
      ps[3] = S1W'(m_ff[0][3]) + S1W'(m_ff[3][0]) + S1W'(m_ff[1][2]) - S1W'(m_ff[2][1]);
   end

   // Stage two: round p back to Q30
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         p_ff[i] <= PW'((ps[i] + HALF_P) >>> qer_pkg::FRAC_BITS);
      end
      q2_ff <= q1_ff;
   end

   // Stage three: all p by q partial products
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            n_ff[i][j] <= P2W'(p_ff[i]) * P2W'(q2_ff[j]);
         end
      end
   end

   // Sum p * conj(q)
   always_comb begin
      os[0] = S2W'(n_ff[0][0]) + S2W'(n_ff[1][1]) + S2W'(n_ff[2][2]) + S2W'(n_ff[3][3]);
      os[1] = S2W'(n_ff[1][0]) - S2W'(n_ff[0][1]) - S2W'(n_ff[2][3]) + S2W'(n_ff[3][2]);
      os[2] = S2W'(n_ff[2][0]) - S2W'(n_ff[0][2]) - S2W'(n_ff[3][1]) + S2W'(n_ff[1][3]);
      os[3] = S2W'(n_ff[3][0]) - S2W'(n_ff[0][3]) - S2W'(n_ff[1][2]) + S2W'(n_ff[2][1]);
   end

   // Stage four: round, saturate and register the result beat
   always_ff @(posedge clock) begin
      rsp_ff.r_w <= sat16(os[0]);
      rsp_ff.r_x <= sat16(os[1]);
      rsp_ff.r_y <= sat16(os[2]);
      rsp_ff.r_z <= sat16(os[3]);
   end

   assign rsp_valid = v_ff[3];
   assign rsp_data  = rsp_ff;

endmodule
